>>> rtl/core/qer_pkg.sv
// Shared types for the quadratic evaluator and root solver.
// Holds the root-kind codes and the cell state structs; no dependencies.
package qer_pkg;

  // Root classification codes carried with each result.
  typedef enum logic [1:0] {
    KIND_DISTINCT = 2'd0,
    KIND_EQUAL    = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } kind_t;

  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned DIV_STEPS  = 34;

  // State handed from one square root cell to the next.
  typedef struct packed {
    logic [49:0] rad;
    logic [25:0] rem;
    logic [24:0] root;
  } sqrt_t;

  // State handed from one divider cell to the next.
  typedef struct packed {
    logic [33:0] nq;
    logic [16:0] rem;
    logic [16:0] den;
  } div_t;

  // Side data that travels beside the square root cells.
  typedef struct packed {
    logic               valid;
    logic [31:0]        poly;
    kind_t              kind;
    logic signed [24:0] nb;
    logic signed [15:0] a;
  } sq_side_t;

  // Side data that travels beside the divider cells.
  typedef struct packed {
    logic        valid;
    logic [31:0] poly;
    kind_t       kind;
    logic        neg0;
    logic        neg1;
  } dv_side_t;

endpackage

>>> rtl/core/qer_sqrt_cell.sv
// One step of the restoring integer square root: one result bit per cell.
// Depends on qer_pkg for the sqrt_t state struct.
module qer_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  qer_pkg::sqrt_t st_in,
  output qer_pkg::sqrt_t st_out
);
  import qer_pkg::*;

  logic [27:0] acc_w;
  logic [27:0] trial;
  logic [27:0] diff;
  logic        ge;
  sqrt_t       st_nxt;

  always_comb begin
    acc_w  = {st_in.rem, st_in.rad[49:48]};
    trial  = {1'b0, st_in.root, 2'b01};
    ge     = (acc_w >= trial);
    diff   = acc_w - trial;
    st_nxt.rad  = {st_in.rad[47:0], 2'b00};
    st_nxt.rem  = ge ? diff[25:0] : acc_w[25:0];
    st_nxt.root = {st_in.root[23:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_nxt;
    end
  end

endmodule

>>> rtl/core/qer_div_cell.sv
// One step of the restoring unsigned divider: one quotient bit per cell.
// Depends on qer_pkg for the div_t state struct.
module qer_div_cell (
  input  logic          clk,
  input  logic          en,
  input  qer_pkg::div_t st_in,
  output qer_pkg::div_t st_out
);
  import qer_pkg::*;

  logic [17:0] part;
  logic [17:0] diff;
  logic        ge;
  div_t        st_nxt;

  always_comb begin
    part = {st_in.rem, st_in.nq[33]};
    ge   = (part >= {1'b0, st_in.den});
    diff = part - {1'b0, st_in.den};
    st_nxt.nq  = {st_in.nq[32:0], ge};
    st_nxt.rem = ge ? diff[16:0] : part[16:0];
    st_nxt.den = st_in.den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out <= st_nxt;
    end
  end

endmodule

>>> rtl/core/quadratic_eval_and_roots.sv
// Quadratic evaluator and root solver, top level: one transaction per clock unless a result
// waits on out_tready. From input transaction to out_tvalid the data passes 3 arithmetic stages,
// 25 square root cells, 1 setup stage, 34 divider cells, 1 output register; all move together.
// Reset (rst_n, synchronous, active low) clears every valid bit; data registers are not reset.
// Depends on qer_pkg, qer_sqrt_cell and qer_div_cell.
module quadratic_eval_and_roots (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // coef_a, coef_b, coef_c, point_x (16 bits each)
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // poly_value 32, root_first 32, root_second 32, saturated 1
  output logic [1:0]   out_tuser   // root_kind
);
  import qer_pkg::*;

  // The whole pipe advances when the output slot is free or being drained. A result that
  // waits in the output register while out_tready is low freezes every stage, so in that
  // case in_tready drops together with out_tready and no new transaction is taken.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: the four 16x16 products.
  logic               s1_vld_r;
  logic signed [31:0] s1_ax_r, s1_bb_r, s1_ac_r, s1_bx_r;
  logic signed [15:0] s1_a_r, s1_b_r, s1_c_r, s1_x_r;

  // Stage 2: a*x*x, the linear and constant terms, and the discriminant.
  logic               s2_vld_r;
  logic signed [47:0] s2_axx_r, s2_part_r;
  logic signed [34:0] s2_disc_r;
  logic signed [15:0] s2_a_r, s2_b_r;

  // Stage 3 feeds the first square root cell.
  sqrt_t    s3_st_r;
  sq_side_t s3_side_r;

  logic signed [15:0] in_a, in_b, in_c, in_x;
  assign in_a = in_tdata[15:0];
  assign in_b = in_tdata[31:16];
  assign in_c = in_tdata[47:32];
  assign in_x = in_tdata[63:48];

  // Stage 3 combinational values.
  logic signed [47:0] acc;
  logic [47:0]        acc_mag;
  logic [47:0]        poly_mag;
  logic [31:0]        poly_val;
  logic signed [34:0] disc_abs;
  kind_t              kind_s3;

  always_comb begin
    acc      = s2_axx_r + s2_part_r;
    acc_mag  = acc[47] ? 48'(-acc) : 48'(acc);
    // Round to nearest with ties away from zero on the magnitude, then restore the sign.
    poly_mag = (acc_mag + 48'd32768) >> 16;
    poly_val = acc[47] ? 32'(-poly_mag[31:0]) : poly_mag[31:0];
    disc_abs = s2_disc_r[34] ? -s2_disc_r : s2_disc_r;
    priority if (s2_a_r == 16'sd0) begin
      kind_s3 = KIND_A_ZERO;
    end else if (s2_disc_r == 35'sd0) begin
      kind_s3 = KIND_EQUAL;
    end else if (s2_disc_r[34]) begin
      kind_s3 = KIND_COMPLEX;
    end else begin
      kind_s3 = KIND_DISTINCT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      s2_vld_r        <= 1'b0;
      s3_side_r.valid <= 1'b0;
    end else if (en) begin
      s1_vld_r        <= in_tvalid;
      s2_vld_r        <= s1_vld_r;
      s3_side_r.valid <= s2_vld_r;
      s3_side_r.poly  <= poly_val;
      s3_side_r.kind  <= kind_s3;
      s3_side_r.nb    <= -(25'(s2_b_r) <<< 8);
      s3_side_r.a     <= s2_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax_r <= in_a * in_x;
      s1_bb_r <= in_b * in_b;
      s1_ac_r <= in_a * in_c;
      s1_bx_r <= in_b * in_x;
      s1_a_r  <= in_a;
      s1_b_r  <= in_b;
      s1_c_r  <= in_c;
      s1_x_r  <= in_x;

      s2_axx_r  <= 48'(s1_ax_r) * 48'(s1_x_r);
      s2_part_r <= (48'(s1_bx_r) <<< 8) + (48'(s1_c_r) <<< 16);
      s2_disc_r <= 35'(s1_bb_r) - (35'(s1_ac_r) <<< 2);
      s2_a_r    <= s1_a_r;
      s2_b_r    <= s1_b_r;

      s3_st_r.rad  <= {disc_abs[33:0], 16'b0};
      s3_st_r.rem  <= '0;
      s3_st_r.root <= '0;
    end
  end

  // Square root chain: sqrt(|D| * 2^16), truncated, one bit per cell.
  sqrt_t    sq_st   [0:SQRT_STEPS];
  sq_side_t sq_side [0:SQRT_STEPS];

  assign sq_st[0]   = s3_st_r;
  assign sq_side[0] = s3_side_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    qer_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .st_in  (sq_st[i]),
      .st_out (sq_st[i+1])
    );

    sq_side_t side_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r.valid <= 1'b0;
      end else if (en) begin
        side_r <= sq_side[i];
      end
    end
    assign sq_side[i+1] = side_r;
  end

  // Setup stage: build the two numerators and the shared divisor. For distinct and equal
  // roots the lanes divide (-b*256 +/- S)*128 by a; for a complex pair lane 0 gives the real
  // part and lane 1 divides S*128 by |a|. The divider forms floor((2n + d) / 2d), which is
  // the rounded quotient with ties away from zero.
  sq_side_t           sq_last;
  logic [24:0]        sq_root;
  logic               cplx;
  logic signed [26:0] num0, num1, s_ext;
  logic [25:0]        mag0, mag1;
  logic [15:0]        den_mag;
  logic [16:0]        den2;

  assign sq_last = sq_side[SQRT_STEPS];
  assign sq_root = sq_st[SQRT_STEPS].root;

  always_comb begin
    cplx    = (sq_last.kind == KIND_COMPLEX);
    s_ext   = $signed({2'b00, sq_root});
    num0    = 27'(sq_last.nb) + (cplx ? 27'sd0 : s_ext);
    num1    = cplx ? s_ext : 27'(sq_last.nb) - s_ext;
    mag0    = num0[26] ? 26'(-num0) : num0[25:0];
    mag1    = num1[26] ? 26'(-num1) : num1[25:0];
    // A zero a gets a dummy divisor; its roots are forced to zero at the end.
    den_mag = (sq_last.a == 16'sd0) ? 16'd1 :
              (sq_last.a[15] ? 16'(-sq_last.a) : 16'(sq_last.a));
    den2    = {den_mag, 1'b0};
  end

  div_t     su_st0_r, su_st1_r;
  dv_side_t su_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_side_r.valid <= 1'b0;
    end else if (en) begin
      su_side_r.valid <= sq_last.valid;
      su_side_r.poly  <= sq_last.poly;
      su_side_r.kind  <= sq_last.kind;
      su_side_r.neg0  <= num0[26] ^ sq_last.a[15];
      su_side_r.neg1  <= cplx ? 1'b0 : (num1[26] ^ sq_last.a[15]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_st0_r.nq  <= {mag0, 8'b0} + 34'(den_mag);
      su_st0_r.rem <= '0;
      su_st0_r.den <= den2;
      su_st1_r.nq  <= {mag1, 8'b0} + 34'(den_mag);
      su_st1_r.rem <= '0;
      su_st1_r.den <= den2;
    end
  end

  // Divider chains: two lanes of cells side by side, one quotient bit per cell.
  div_t     dv0_st  [0:DIV_STEPS];
  div_t     dv1_st  [0:DIV_STEPS];
  dv_side_t dv_side [0:DIV_STEPS];

  assign dv0_st[0]  = su_st0_r;
  assign dv1_st[0]  = su_st1_r;
  assign dv_side[0] = su_side_r;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    qer_div_cell u_lane0 (
      .clk    (clk),
      .en     (en),
      .st_in  (dv0_st[j]),
      .st_out (dv0_st[j+1])
    );
    qer_div_cell u_lane1 (
      .clk    (clk),
      .en     (en),
      .st_in  (dv1_st[j]),
      .st_out (dv1_st[j+1])
    );

    dv_side_t side_r;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r.valid <= 1'b0;
      end else if (en) begin
        side_r <= dv_side[j];
      end
    end
    assign dv_side[j+1] = side_r;
  end

  // Apply the sign and clip to the signed 32-bit range.
  function automatic logic [32:0] sign_sat(input logic [33:0] q, input logic neg);
    logic [32:0] res;
    if (neg) begin
      if (q > 34'h0_8000_0000) begin
        res = {1'b1, 32'h8000_0000};
      end else begin
        res = {1'b0, 32'(-q[31:0])};
      end
    end else begin
      if (q > 34'h0_7FFF_FFFF) begin
        res = {1'b1, 32'h7FFF_FFFF};
      end else begin
        res = {1'b0, q[31:0]};
      end
    end
    return res;
  endfunction

  dv_side_t           dv_last;
  logic [32:0]        lane0, lane1;
  logic signed [31:0] p_val, q_val;
  logic [31:0]        first_nxt, second_nxt;
  logic               sat_nxt;

  assign dv_last = dv_side[DIV_STEPS];

  always_comb begin
    lane0 = sign_sat(dv0_st[DIV_STEPS].nq, dv_last.neg0);
    lane1 = sign_sat(dv1_st[DIV_STEPS].nq, dv_last.neg1);
    p_val = $signed(lane0[31:0]);
    q_val = $signed(lane1[31:0]);
    unique case (dv_last.kind)
      KIND_A_ZERO: begin
        first_nxt  = '0;
        second_nxt = '0;
        sat_nxt    = 1'b0;
      end
      KIND_COMPLEX: begin
        first_nxt  = lane0[31:0];
        second_nxt = lane1[31:0];
        sat_nxt    = lane0[32] | lane1[32];
      end
      default: begin
        // Distinct and equal roots: larger root first, whatever the sign of a.
        first_nxt  = (p_val > q_val) ? lane0[31:0] : lane1[31:0];
        second_nxt = (p_val > q_val) ? lane1[31:0] : lane0[31:0];
        sat_nxt    = lane0[32] | lane1[32];
      end
    endcase
  end

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_poly_r, out_first_r, out_second_r;
  logic [1:0]  out_kind_r;
  logic        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_poly_r   <= dv_last.poly;
      out_kind_r   <= dv_last.kind;
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
      out_sat_r    <= sat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_sat_r, out_second_r, out_first_r, out_poly_r};
  assign out_tuser  = out_kind_r;

endmodule
